>>> hw/rtl/rlkd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlkd_pkg
// Shared types and constants of the resistor ladder key decoder.
// ----------------------------------------------------------------------------
package rlkd_pkg;

    localparam int MAX_ENTRIES_DEF = 5;
    localparam int ADC_BITS_DEF    = 12;

    localparam int LEVEL_W   = 12;
    localparam int KEY_W     = 8;
    localparam int LEVELS_W  = 60;
    localparam int KEYS_W    = 40;
    localparam int COUNT_W   = 3;
    localparam int TIME_W    = 32;
    localparam int HOLD_W    = 16;
    localparam int TOL_W     = 13;
    localparam int DIFF_W    = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 60;

    localparam logic [DIFF_W-1:0] NO_MATCH_DIFF = 15'd32767;
    localparam logic [KEY_W-1:0]  LONG_EVENT    = 8'hFF;
    localparam logic [KEY_W-1:0]  NO_KEY        = 8'h00;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LADDER_LEVELS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LADDER_KEYS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_CODE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME_MS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_TOLERANCE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TIME_MS  = 3'd6;

    localparam logic [HOLD_W-1:0] HOLD_RESET   = 16'd1000;
    localparam logic [TOL_W-1:0]  TOL_RESET    = 13'd100;
    localparam logic [HOLD_W-1:0] SETTLE_RESET = 16'd50;

    typedef struct packed {
        logic [LEVELS_W-1:0] ladder_levels;
        logic [KEYS_W-1:0]   ladder_keys;
        logic [COUNT_W-1:0]  entry_count;
        logic [TOL_W-1:0]    match_tolerance;
    } match_cfg_t;

    typedef struct packed {
        logic [KEY_W-1:0]  select_code;
        logic [HOLD_W-1:0] hold_time_ms;
        logic [HOLD_W-1:0] settle_time_ms;
    } track_cfg_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_event;
        logic             long_active;
    } track_out_t;

endpackage

>>> hw/rtl/rlkd_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlkd_match
// Nearest ladder level search with tolerance check; gives the decoded key.
// ----------------------------------------------------------------------------
module rlkd_match #(
    parameter int MAX_ENTRIES = rlkd_pkg::MAX_ENTRIES_DEF,
    parameter int ADC_BITS    = rlkd_pkg::ADC_BITS_DEF
) (
    input  logic [rlkd_pkg::LEVEL_W-1:0] adc_sample,
    input  rlkd_pkg::match_cfg_t         cfg,
    output logic [rlkd_pkg::KEY_W-1:0]   key
);

    localparam logic [rlkd_pkg::LEVEL_W-1:0] ADC_MASK =
        rlkd_pkg::LEVEL_W'((1 << ADC_BITS) - 1);
    localparam logic [rlkd_pkg::COUNT_W-1:0] MAX_COUNT =
        rlkd_pkg::COUNT_W'(MAX_ENTRIES);

    logic [rlkd_pkg::COUNT_W-1:0] count;
    logic [rlkd_pkg::LEVEL_W-1:0] sample;
    logic [rlkd_pkg::LEVEL_W-1:0] level [MAX_ENTRIES];
    logic [rlkd_pkg::LEVEL_W-1:0] diff  [MAX_ENTRIES];
    logic [rlkd_pkg::DIFF_W-1:0]  best_diff;
    logic [rlkd_pkg::KEY_W-1:0]   best_key;
    logic                         found;

    assign count  = (cfg.entry_count > MAX_COUNT) ? MAX_COUNT : cfg.entry_count;
    assign sample = adc_sample & ADC_MASK;

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            level[i] = cfg.ladder_levels[rlkd_pkg::LEVEL_W*i +: rlkd_pkg::LEVEL_W] & ADC_MASK;
            diff[i]  = (sample >= level[i]) ? (sample - level[i]) : (level[i] - sample);
        end
    end

    // strict compare keeps the lowest index on ties
    always_comb begin
        best_diff = rlkd_pkg::NO_MATCH_DIFF;
        best_key  = rlkd_pkg::NO_KEY;
        found     = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if ((rlkd_pkg::COUNT_W'(i) < count) &&
                (rlkd_pkg::DIFF_W'(diff[i]) < best_diff)) begin
                best_diff = rlkd_pkg::DIFF_W'(diff[i]);
                best_key  = cfg.ladder_keys[rlkd_pkg::KEY_W*i +: rlkd_pkg::KEY_W];
                found     = 1'b1;
            end
        end
    end

    assign key = (found && (rlkd_pkg::TOL_W'(best_diff) < cfg.match_tolerance))
                 ? best_key : rlkd_pkg::NO_KEY;

endmodule

>>> hw/rtl/rlkd_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlkd_track
// Key state tracking: select click and long press, debounce of other keys.
// ----------------------------------------------------------------------------
module rlkd_track (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [rlkd_pkg::KEY_W-1:0]    key,
    input  logic [rlkd_pkg::TIME_W-1:0]   now_ms,
    input  rlkd_pkg::track_cfg_t          cfg,
    output rlkd_pkg::track_out_t          result
);

    logic [rlkd_pkg::KEY_W-1:0]  prev_key_reg,        prev_key_next;
    logic [rlkd_pkg::TIME_W-1:0] last_change_ms_reg,  last_change_ms_next;
    logic [rlkd_pkg::TIME_W-1:0] select_start_ms_reg, select_start_ms_next;
    logic                        tracking_reg,        tracking_next;
    logic                        long_fired_reg,      long_fired_next;

    logic [rlkd_pkg::TIME_W-1:0] held_ms;
    logic [rlkd_pkg::TIME_W-1:0] since_change_ms;
    logic [rlkd_pkg::KEY_W-1:0]  event_code;

    // time differences wrap modulo 2^32
    assign held_ms         = now_ms - select_start_ms_reg;
    assign since_change_ms = now_ms - last_change_ms_reg;

    always_comb begin
        prev_key_next        = prev_key_reg;
        last_change_ms_next  = last_change_ms_reg;
        select_start_ms_next = select_start_ms_reg;
        tracking_next        = tracking_reg;
        long_fired_next      = long_fired_reg;
        event_code           = rlkd_pkg::NO_KEY;
        if (key == cfg.select_code) begin
            if (!tracking_reg) begin
                tracking_next        = 1'b1;
                select_start_ms_next = now_ms;
                long_fired_next      = 1'b0;
                prev_key_next        = key;
            end else if (!long_fired_reg &&
                         held_ms >= rlkd_pkg::TIME_W'(cfg.hold_time_ms)) begin
                long_fired_next = 1'b1;
                event_code      = rlkd_pkg::LONG_EVENT;
            end
        end else if (prev_key_reg == cfg.select_code && tracking_reg) begin
            // select released; click only if no long press fired
            tracking_next   = 1'b0;
            long_fired_next = 1'b0;
            prev_key_next   = key;
            if (!long_fired_reg) begin
                last_change_ms_next = now_ms;
                event_code          = cfg.select_code;
            end
        end else if (key != prev_key_reg &&
                     since_change_ms > rlkd_pkg::TIME_W'(cfg.settle_time_ms)) begin
            prev_key_next       = key;
            last_change_ms_next = now_ms;
            event_code          = key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_key_reg        <= rlkd_pkg::NO_KEY;
            last_change_ms_reg  <= '0;
            select_start_ms_reg <= '0;
            tracking_reg        <= 1'b0;
            long_fired_reg      <= 1'b0;
        end else if (step) begin
            prev_key_reg        <= prev_key_next;
            last_change_ms_reg  <= last_change_ms_next;
            select_start_ms_reg <= select_start_ms_next;
            tracking_reg        <= tracking_next;
            long_fired_reg      <= long_fired_next;
        end
    end

    assign result.key_event   = event_code;
    assign result.long_active = long_fired_next;

endmodule

>>> hw/rtl/resistor_ladder_key_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resistor_ladder_key_decoder
// Analog keypad decoder for a resistor ladder read through an ADC.
// ----------------------------------------------------------------------------
// Each sample transfer (ADC reading plus millisecond timestamp) yields exactly
// one result transfer carrying the key event, a pressed flag and a long-press
// flag. A sample is captured in an input register, decoded and run through the
// key tracking, and the result lands in an output register, so the block takes
// one sample per clock unless the output stalls. s_axis_tready stays high while
// the output register is free or being read; the combinational nearest-level
// search and tracking update set that rate. The user must write configuration
// via cfg_wr_en / cfg_addr / cfg_wdata only while no sample is in flight; the
// block does not enforce this. Writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module resistor_ladder_key_decoder #(
    parameter int MAX_ENTRIES = rlkd_pkg::MAX_ENTRIES_DEF,
    parameter int ADC_BITS    = rlkd_pkg::ADC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic [rlkd_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [rlkd_pkg::CFG_W-1:0]      cfg_wdata,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [11:0] adc_sample, [43:12] now_ms, [47:44] zero
    input  logic [47:0]                     s_axis_tdata,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] key_event, [8] any_pressed, [9] long_active, [15:10] zero
    output logic [15:0]                     m_axis_tdata
);

    rlkd_pkg::match_cfg_t match_cfg_reg;
    rlkd_pkg::track_cfg_t track_cfg_reg;

    logic                                in_valid_reg;
    logic [rlkd_pkg::LEVEL_W-1:0]        in_sample_reg;
    logic [rlkd_pkg::TIME_W-1:0]         in_now_reg;

    logic                                out_valid_reg;
    logic [rlkd_pkg::KEY_W-1:0]          out_event_reg;
    logic                                out_pressed_reg;
    logic                                out_long_reg;

    logic                                s_transfer;
    logic                                advance;
    logic [rlkd_pkg::KEY_W-1:0]          key;
    rlkd_pkg::track_out_t                trk_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_cfg_reg.ladder_levels   <= '0;
            match_cfg_reg.ladder_keys     <= '0;
            match_cfg_reg.entry_count     <= '0;
            match_cfg_reg.match_tolerance <= rlkd_pkg::TOL_RESET;
            track_cfg_reg.select_code     <= rlkd_pkg::NO_KEY;
            track_cfg_reg.hold_time_ms    <= rlkd_pkg::HOLD_RESET;
            track_cfg_reg.settle_time_ms  <= rlkd_pkg::SETTLE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                rlkd_pkg::REG_LADDER_LEVELS: begin
                    match_cfg_reg.ladder_levels <= cfg_wdata[rlkd_pkg::LEVELS_W-1:0];
                end
                rlkd_pkg::REG_LADDER_KEYS: begin
                    match_cfg_reg.ladder_keys <= cfg_wdata[rlkd_pkg::KEYS_W-1:0];
                end
                rlkd_pkg::REG_ENTRY_COUNT: begin
                    match_cfg_reg.entry_count <= cfg_wdata[rlkd_pkg::COUNT_W-1:0];
                end
                rlkd_pkg::REG_SELECT_CODE: begin
                    track_cfg_reg.select_code <= cfg_wdata[rlkd_pkg::KEY_W-1:0];
                end
                rlkd_pkg::REG_HOLD_TIME_MS: begin
                    track_cfg_reg.hold_time_ms <= cfg_wdata[rlkd_pkg::HOLD_W-1:0];
                end
                rlkd_pkg::REG_MATCH_TOLERANCE: begin
                    match_cfg_reg.match_tolerance <= cfg_wdata[rlkd_pkg::TOL_W-1:0];
                end
                rlkd_pkg::REG_SETTLE_TIME_MS: begin
                    track_cfg_reg.settle_time_ms <= cfg_wdata[rlkd_pkg::HOLD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input register moves on whenever the output register is free or read
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_transfer    = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_transfer) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_transfer) begin
            in_sample_reg <= s_axis_tdata[11:0];
            in_now_reg    <= s_axis_tdata[43:12];
        end
    end

    rlkd_match #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ADC_BITS    (ADC_BITS)
    ) u_match (
        .adc_sample (in_sample_reg),
        .cfg        (match_cfg_reg),
        .key        (key)
    );

    rlkd_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .key     (key),
        .now_ms  (in_now_reg),
        .cfg     (track_cfg_reg),
        .result  (trk_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_event_reg   <= trk_out.key_event;
            out_pressed_reg <= (key != rlkd_pkg::NO_KEY);
            out_long_reg    <= trk_out.long_active;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_long_reg, out_pressed_reg, out_event_reg};

endmodule

>>> hw/rtl/rlkd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlkd_port_checks
// Port-level checks of the resistor ladder key decoder, bound to the top.
// ----------------------------------------------------------------------------
module rlkd_port_checks (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // a held result keeps its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a sample taken while no result is held reaches the output through the input and output registers
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
        else $error("result missing two cycles after sample transfer");

    // a ready sink never holds off the source side
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is being read");

    // unused result bits stay zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[15:10] == 6'd0)
        else $error("result pad bits not zero");

endmodule

bind resistor_ladder_key_decoder rlkd_port_checks u_rlkd_port_checks (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> test/rlkd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlkd_checker
// Watches the configuration port and both streams of the key decoder. Every
// accepted sample is run through a local decode and key tracking model, and
// each result transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rlkd_checker (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic [rlkd_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [rlkd_pkg::CFG_W-1:0]      cfg_wdata,

    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // [11:0] adc_sample, [43:12] now_ms, [47:44] zero
    input  logic [47:0]                     s_tdata,

    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] key_event, [8] any_pressed, [9] long_active, [15:10] zero
    input  logic [15:0]                     m_tdata,

    output int                              fail_total,
    output int                              pending_results
);

    localparam int unsigned ADC_MASK = (1 << rlkd_pkg::ADC_BITS_DEF) - 1;

    // register copies
    logic [rlkd_pkg::LEVELS_W-1:0] levels_cfg;
    logic [rlkd_pkg::KEYS_W-1:0]   keys_cfg;
    logic [rlkd_pkg::COUNT_W-1:0]  count_cfg;
    logic [rlkd_pkg::KEY_W-1:0]    sel_code;
    logic [rlkd_pkg::HOLD_W-1:0]   hold_ms;
    logic [rlkd_pkg::TOL_W-1:0]    tol_cfg;
    logic [rlkd_pkg::HOLD_W-1:0]   settle_ms;

    // key tracking state
    logic [rlkd_pkg::KEY_W-1:0]    held_key;
    logic [31:0]                   change_ms;
    logic [31:0]                   sel_start_ms;
    logic                          sel_track;
    logic                          long_done;

    logic [15:0]         expected_events[$];
    logic [15:0]         want;
    int                  result_idx = 0;

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        fail_total++;
        if (fail_total <= 50)
            $display("[%0t] result transfer %0d: %s got 0x%0h, wanted 0x%0h",
                     $realtime, result_idx, field, got, exp_val);
    endtask

    // nearest configured level, lowest index wins a tie
    function automatic logic [rlkd_pkg::KEY_W-1:0] nearest_key(input logic [11:0] sample);
        int unsigned n;
        int unsigned best;
        int unsigned idx;
        int unsigned lvl;
        int unsigned delta;
        bit          hit;
        n    = (count_cfg > rlkd_pkg::MAX_ENTRIES_DEF) ? rlkd_pkg::MAX_ENTRIES_DEF : count_cfg;
        best = 32'(rlkd_pkg::NO_MATCH_DIFF);
        idx  = 0;
        hit  = 1'b0;
        for (int i = 0; i < n; i++) begin
            lvl   = levels_cfg[rlkd_pkg::LEVEL_W*i +: rlkd_pkg::LEVEL_W] & ADC_MASK;
            delta = (sample >= lvl) ? sample - lvl : lvl - sample;
            if (delta < best) begin
                best = delta;
                idx  = i;
                hit  = 1'b1;
            end
        end
        if (hit && best < tol_cfg)
            return keys_cfg[rlkd_pkg::KEY_W*idx +: rlkd_pkg::KEY_W];
        return rlkd_pkg::NO_KEY;
    endfunction

    function automatic logic [15:0] decode_and_track(input logic [11:0] sample_in,
                                                     input logic [31:0] now);
        logic [11:0]                sample;
        logic [rlkd_pkg::KEY_W-1:0] key;
        logic [rlkd_pkg::KEY_W-1:0] evt;
        logic [31:0]                since;
        logic                       was_long;
        sample = sample_in & ADC_MASK[11:0];
        key    = nearest_key(sample);
        evt    = rlkd_pkg::NO_KEY;
        if (key == sel_code) begin
            since = now - sel_start_ms;
            if (!sel_track) begin
                sel_track    = 1'b1;
                sel_start_ms = now;
                long_done    = 1'b0;
                held_key     = key;
            end else if (!long_done && since >= {16'd0, hold_ms}) begin
                long_done = 1'b1;
                evt       = rlkd_pkg::LONG_EVENT;
            end
        end else if (held_key == sel_code && sel_track) begin
            // select released: click only if no long press went out
            was_long  = long_done;
            sel_track = 1'b0;
            long_done = 1'b0;
            held_key  = key;
            if (!was_long) begin
                change_ms = now;
                evt       = sel_code;
            end
        end else begin
            since = now - change_ms;
            if (key != held_key && since > {16'd0, settle_ms}) begin
                held_key  = key;
                change_ms = now;
                evt       = key;
            end
        end
        return {6'd0, long_done, key != rlkd_pkg::NO_KEY, evt};
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            levels_cfg   = '0;
            keys_cfg     = '0;
            count_cfg    = '0;
            sel_code     = '0;
            hold_ms      = rlkd_pkg::HOLD_RESET;
            tol_cfg      = rlkd_pkg::TOL_RESET;
            settle_ms    = rlkd_pkg::SETTLE_RESET;
            held_key     = rlkd_pkg::NO_KEY;
            change_ms    = '0;
            sel_start_ms = '0;
            sel_track    = 1'b0;
            long_done    = 1'b0;
            expected_events.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    rlkd_pkg::REG_LADDER_LEVELS:
                        levels_cfg = cfg_wdata[rlkd_pkg::LEVELS_W-1:0];
                    rlkd_pkg::REG_LADDER_KEYS:
                        keys_cfg   = cfg_wdata[rlkd_pkg::KEYS_W-1:0];
                    rlkd_pkg::REG_ENTRY_COUNT:
                        count_cfg  = cfg_wdata[rlkd_pkg::COUNT_W-1:0];
                    rlkd_pkg::REG_SELECT_CODE:
                        sel_code   = cfg_wdata[rlkd_pkg::KEY_W-1:0];
                    rlkd_pkg::REG_HOLD_TIME_MS:
                        hold_ms    = cfg_wdata[rlkd_pkg::HOLD_W-1:0];
                    rlkd_pkg::REG_MATCH_TOLERANCE:
                        tol_cfg    = cfg_wdata[rlkd_pkg::TOL_W-1:0];
                    rlkd_pkg::REG_SETTLE_TIME_MS:
                        settle_ms  = cfg_wdata[rlkd_pkg::HOLD_W-1:0];
                    default: ;
                endcase
            end
            // results leave before a same-cycle sample can be predicted
            if (m_tvalid && m_tready) begin
                if (expected_events.size() == 0) begin
                    report_mismatch("result with nothing expected", {16'd0, m_tdata}, 0);
                end else begin
                    want = expected_events.pop_front();
                    if (m_tdata[7:0] != want[7:0])
                        report_mismatch("key_event", 32'(m_tdata[7:0]), 32'(want[7:0]));
                    if (m_tdata[8] != want[8])
                        report_mismatch("any_pressed", 32'(m_tdata[8]), 32'(want[8]));
                    if (m_tdata[9] != want[9])
                        report_mismatch("long_active", 32'(m_tdata[9]), 32'(want[9]));
                    if (m_tdata[15:10] != want[15:10])
                        report_mismatch("pad bits", 32'(m_tdata[15:10]), 32'(want[15:10]));
                end
                result_idx++;
            end
            if (s_tvalid && s_tready)
                expected_events.push_back(decode_and_track(s_tdata[11:0], s_tdata[43:12]));
        end
        pending_results <= expected_events.size();
    end

endmodule

>>> test/tb_resistor_ladder_key_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_resistor_ladder_key_decoder
// Drives samples into the ladder key decoder: a directed run over ties,
// tolerance edges, debounce, clicks, long presses and time wrap, then random
// press and release sequences under several ladder settings. Both streams
// idle at random; rlkd_checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_resistor_ladder_key_decoder;

    localparam int LIMIT_NS = 5_000_000;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 100;
    // index beyond the register map, writes must be dropped
    localparam logic [rlkd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [rlkd_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
    logic [rlkd_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [47:0]                    s_axis_tdata = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [15:0]                    m_axis_tdata;

    int  fail_total;
    int  pending_results;
    bit  send_calm = 1'b0;
    bit  recv_calm = 1'b0;
    int  stall_left = 0;

    // ladder currently programmed, used to aim samples and time steps
    logic [rlkd_pkg::LEVELS_W-1:0] cur_levels;
    logic [rlkd_pkg::KEYS_W-1:0]   cur_keys;
    logic [rlkd_pkg::KEY_W-1:0]    cur_select;
    int                            cur_count;
    int                            cur_hold;
    int                            cur_tol;
    int                            cur_settle;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    resistor_ladder_key_decoder u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rlkd_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_axis_tvalid),
        .s_tready        (s_axis_tready),
        .s_tdata         (s_axis_tdata),
        .m_tvalid        (m_axis_tvalid),
        .m_tready        (m_axis_tready),
        .m_tdata         (m_axis_tdata),
        .fail_total      (fail_total),
        .pending_results (pending_results)
    );

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    // steps cluster around the debounce and hold boundaries
    function automatic logic [31:0] step_ms();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom_range(0, 5);
        if (r < 65)
            return cur_settle + $urandom_range(0, 2) - 1;
        if (r < 85)
            return cur_hold + $urandom_range(0, 2) - 1;
        if (r < 95)
            return $urandom_range(0, 2000);
        return $urandom;
    endfunction

    // sample inside the match window of entry j, sometimes right on its edge
    function automatic logic [11:0] near_level(input int j);
        int lvl;
        int span;
        int s;
        lvl  = int'(cur_levels[rlkd_pkg::LEVEL_W*j +: rlkd_pkg::LEVEL_W]);
        span = (cur_tol > 0) ? cur_tol - 1 : 0;
        if ($urandom_range(0, 7) == 0)
            s = $urandom_range(0, 1) ? lvl + cur_tol : lvl - cur_tol;
        else
            s = lvl + int'($urandom_range(0, 2 * span)) - span;
        if (s < 0)
            s = 0;
        if (s > 4095)
            s = 4095;
        return s[11:0];
    endfunction

    task automatic write_reg(input logic [rlkd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rlkd_pkg::CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_sample(input logic [11:0] adc, input logic [31:0] now);
        int gap;
        gap = (!send_calm && $urandom_range(0, 99) < 30) ? idle_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, now, adc};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // hold the sender until every result is back, then let the pipe settle
    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending_results == 0);
        repeat (4) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (!recv_calm && $urandom_range(0, 99) < 25) begin
            m_axis_tready <= 1'b0;
            stall_left    <= idle_len() - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("tb_resistor_ladder_key_decoder: FAIL");
        $finish;
    end

    initial begin
        logic [31:0] clock_ms;
        logic [63:0] wide;
        int          n;
        int          sel_idx;
        int          j;
        int          len;
        int          sent;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: no entries, so every sample is key 0 = select
        send_sample(12'd123, 32'd0);
        send_sample(12'd4095, 32'd999);
        send_sample(12'd0, 32'd1000);
        wait_for_idle();

        write_reg(rlkd_pkg::REG_LADDER_LEVELS,
                  rlkd_pkg::CFG_W'({12'd2048, 12'd4095, 12'd1060, 12'd1000, 12'd0}));
        write_reg(rlkd_pkg::REG_LADDER_KEYS,
                  rlkd_pkg::CFG_W'({8'h80, 8'hFE, 8'h33, 8'h22, 8'h11}));
        write_reg(rlkd_pkg::REG_ENTRY_COUNT, rlkd_pkg::CFG_W'(5));
        write_reg(rlkd_pkg::REG_HOLD_TIME_MS, rlkd_pkg::CFG_W'(100));
        write_reg(rlkd_pkg::REG_MATCH_TOLERANCE, rlkd_pkg::CFG_W'(50));
        write_reg(rlkd_pkg::REG_SETTLE_TIME_MS, rlkd_pkg::CFG_W'(20));
        // releases the select-zero hold after its long press
        send_sample(12'd4095, 32'hFFFF_FFE0);
        wait_for_idle();

        write_reg(rlkd_pkg::REG_SELECT_CODE, rlkd_pkg::CFG_W'(8'h80));
        write_reg(REG_UNUSED, '1);
        send_sample(12'd3000, 32'hFFFF_FFF5);
        send_sample(12'd0, 32'h0000_0010);      // time wraps past zero
        send_sample(12'd4095, 32'h0000_0018);   // too soon, debounced
        send_sample(12'd1030, 32'h0000_0040);   // tie between two levels
        send_sample(12'd1080, 32'h0000_0060);
        send_sample(12'd1110, 32'h0000_0070);   // distance equals tolerance
        send_sample(12'd1109, 32'h0000_0090);
        send_sample(12'd2048, 32'h0000_0100);   // select down
        send_sample(12'd2060, 32'h0000_0150);
        send_sample(12'd2040, 32'h0000_0164);   // held exactly the hold time
        send_sample(12'd2048, 32'h0000_0200);
        send_sample(12'd0, 32'h0000_0201);      // release after long press
        send_sample(12'd2048, 32'h0000_0205);
        send_sample(12'd4095, 32'h0000_0206);   // short press gives a click
        send_sample(12'd0, 32'h0000_0208);
        send_sample(12'd0, 32'h0000_021B);
        wait_for_idle();

        write_reg(rlkd_pkg::REG_ENTRY_COUNT, rlkd_pkg::CFG_W'(7));
        send_sample(12'd4095, 32'h0000_0300);
        wait_for_idle();
        write_reg(rlkd_pkg::REG_ENTRY_COUNT, rlkd_pkg::CFG_W'(0));
        send_sample(12'd2048, 32'h0000_0400);
        wait_for_idle();

        write_reg(rlkd_pkg::REG_ENTRY_COUNT, rlkd_pkg::CFG_W'(5));
        write_reg(rlkd_pkg::REG_SELECT_CODE, rlkd_pkg::CFG_W'(0));
        write_reg(rlkd_pkg::REG_HOLD_TIME_MS, rlkd_pkg::CFG_W'(0));
        write_reg(rlkd_pkg::REG_MATCH_TOLERANCE, rlkd_pkg::CFG_W'(0));
        send_sample(12'd1000, 32'h0000_0500);
        send_sample(12'd1000, 32'h0000_0500);
        wait_for_idle();
        write_reg(rlkd_pkg::REG_MATCH_TOLERANCE, rlkd_pkg::CFG_W'(4096));
        write_reg(rlkd_pkg::REG_HOLD_TIME_MS, rlkd_pkg::CFG_W'(65535));
        write_reg(rlkd_pkg::REG_SETTLE_TIME_MS, rlkd_pkg::CFG_W'(65535));
        send_sample(12'd2500, 32'hFFFF_FFFF);
        wait_for_idle();

        for (int p = 0; p < PHASES; p++) begin
            wide       = {$urandom, $urandom};
            cur_levels = wide[rlkd_pkg::LEVELS_W-1:0];
            wide       = {$urandom, $urandom};
            cur_keys   = wide[rlkd_pkg::KEYS_W-1:0];
            cur_count  = (p == 0) ? 5 : (p == 1 || p == 5) ? 7 : int'($urandom_range(1, 7));
            cur_hold   = $urandom_range(0, 300);
            cur_tol    = $urandom_range(1, 300);
            cur_settle = $urandom_range(0, 100);
            n          = (cur_count > rlkd_pkg::MAX_ENTRIES_DEF) ?
                         rlkd_pkg::MAX_ENTRIES_DEF : cur_count;
            sel_idx    = $urandom_range(0, n - 1);
            cur_select = cur_keys[rlkd_pkg::KEY_W*sel_idx +: rlkd_pkg::KEY_W];
            if (cur_select == rlkd_pkg::LONG_EVENT)
                cur_select = 8'hFE;
            case (p)
                2: begin
                    cur_hold   = 65535;
                    cur_settle = 65535;
                    cur_tol    = 4096;
                    cur_select = 8'hFE;
                    cur_keys[rlkd_pkg::KEY_W*sel_idx +: rlkd_pkg::KEY_W] = 8'hFE;
                end
                3: begin
                    cur_hold   = 0;
                    cur_settle = 0;
                end
                4: cur_levels = '0;
                5: begin
                    cur_levels = '1;
                    cur_keys   = '1;
                    cur_select = rlkd_pkg::NO_KEY;
                end
                default: ;
            endcase
            send_calm <= (p == 3) || (p == 6);
            recv_calm <= (p == 5) || (p == 6);

            write_reg(rlkd_pkg::REG_LADDER_LEVELS, rlkd_pkg::CFG_W'(cur_levels));
            write_reg(rlkd_pkg::REG_LADDER_KEYS, rlkd_pkg::CFG_W'(cur_keys));
            write_reg(rlkd_pkg::REG_ENTRY_COUNT, rlkd_pkg::CFG_W'(cur_count));
            write_reg(rlkd_pkg::REG_SELECT_CODE, rlkd_pkg::CFG_W'(cur_select));
            write_reg(rlkd_pkg::REG_HOLD_TIME_MS, rlkd_pkg::CFG_W'(cur_hold));
            write_reg(rlkd_pkg::REG_MATCH_TOLERANCE, rlkd_pkg::CFG_W'(cur_tol));
            write_reg(rlkd_pkg::REG_SETTLE_TIME_MS, rlkd_pkg::CFG_W'(cur_settle));
            if (p == 6)
                write_reg(REG_UNUSED, rlkd_pkg::CFG_W'(wide));

            clock_ms = $urandom;
            sent     = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 75) begin
                    // hold one key for a while, then let go
                    j   = ($urandom_range(0, 99) < 45) ? sel_idx : int'($urandom_range(0, n - 1));
                    len = $urandom_range(1, 8);
                    repeat (len) begin
                        clock_ms += step_ms();
                        send_sample(near_level(j), clock_ms);
                    end
                    clock_ms += step_ms();
                    send_sample(12'($urandom_range(0, 4095)), clock_ms);
                    sent += len + 1;
                end else begin
                    clock_ms += step_ms();
                    send_sample(12'($urandom_range(0, 4095)), clock_ms);
                    sent++;
                end
            end
            wait_for_idle();
        end

        if (fail_total == 0)
            $display("tb_resistor_ladder_key_decoder: PASS");
        else
            $display("tb_resistor_ladder_key_decoder: FAIL");
        $finish;
    end

endmodule
